/* design/msgd_pkg.sv */
// ----------------------------------------------------------------------------
// msgd_pkg
// Shared types, codes and the type byte classifier of the MessagePack decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package msgd_pkg;

    localparam int MAX_NEST_DEF = 16;
    localparam int OUT_W        = 144;

    typedef enum logic [3:0] {
        K_NIL     = 4'd0,
        K_FALSE   = 4'd1,
        K_TRUE    = 4'd2,
        K_UINT    = 4'd3,
        K_INT     = 4'd4,
        K_F32     = 4'd5,
        K_F64     = 4'd6,
        K_STRHDR  = 4'd7,
        K_STRBYTE = 4'd8,
        K_ARRAY   = 4'd9,
        K_MAP     = 4'd10
    } kind_t;

    typedef enum logic [2:0] {
        OP_SCALAR,
        OP_ARRAY,
        OP_MAP,
        OP_STR,
        OP_FIELD,
        OP_BAD
    } op_t;

    typedef enum logic [1:0] {
        E_NONE  = 2'd0,
        E_BAD   = 2'd1,
        E_SHORT = 2'd2,
        E_DEEP  = 2'd3
    } err_t;

    typedef struct packed {
        op_t        op;
        kind_t      kind;
        logic [7:0] value;
        logic [4:0] count;
        logic [3:0] nbytes;
    } cls_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        cls_t       cls;
    } qent_t;

    typedef struct packed {
        logic  valid;
        qent_t ent;
    } head_t;

    function automatic cls_t classify(input logic [7:0] t);
        cls_t c;
        c.op     = OP_BAD;
        c.kind   = K_NIL;
        c.value  = t;
        c.count  = t[4:0];
        c.nbytes = 4'd0;
        if (t < 8'h80) begin
            c.op   = OP_SCALAR;
            c.kind = K_UINT;
        end else if (t <= 8'h8f) begin
            c.op    = OP_MAP;
            c.count = {1'b0, t[3:0]};
        end else if (t <= 8'h9f) begin
            c.op    = OP_ARRAY;
            c.count = {1'b0, t[3:0]};
        end else if (t <= 8'hbf) begin
            c.op = OP_STR;
        end else if (t >= 8'he0) begin
            c.op   = OP_SCALAR;
            c.kind = K_INT;
        end else begin
            unique case (t) inside
                8'hc0: begin
                    c.op   = OP_SCALAR;
                    c.kind = K_NIL;
                end
                8'hc2: begin
                    c.op   = OP_SCALAR;
                    c.kind = K_FALSE;
                end
                8'hc3: begin
                    c.op   = OP_SCALAR;
                    c.kind = K_TRUE;
                end
                8'hcc, 8'hd0: begin
                    c.op     = OP_FIELD;
                    c.nbytes = 4'd1;
                end
                8'hcd, 8'hd1, 8'hda, 8'hdc, 8'hde: begin
                    c.op     = OP_FIELD;
                    c.nbytes = 4'd2;
                end
                8'hca, 8'hce, 8'hd2, 8'hdb, 8'hdd, 8'hdf: begin
                    c.op     = OP_FIELD;
                    c.nbytes = 4'd4;
                end
                8'hcb, 8'hcf, 8'hd3: begin
                    c.op     = OP_FIELD;
                    c.nbytes = 4'd8;
                end
                default: c.op = OP_BAD;
            endcase
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* design/msgd_front.sv */
// ----------------------------------------------------------------------------
// msgd_front
// Accepts stream words, classifies each as a type byte and queues two deep.
// ----------------------------------------------------------------------------
`default_nettype none

module msgd_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,
    input  wire logic          s_tlast,
    output msgd_pkg::head_t    head,
    input  wire logic          pop
);

    msgd_pkg::qent_t q_reg [2];
    logic            wptr_reg, rptr_reg;
    logic [1:0]      cnt_reg;
    logic            push;

    assign s_tready   = (cnt_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign head.valid = (cnt_reg != 2'd0);
    assign head.ent   = q_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wptr_reg] <= '{data: s_tdata, last: s_tlast,
                                 cls: msgd_pkg::classify(s_tdata)};
        end
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

/* design/msgd_back.sv */
// ----------------------------------------------------------------------------
// msgd_back
// Parses queued bytes, keeps the container count stack and builds tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module msgd_back #(
    parameter int MAX_NEST = msgd_pkg::MAX_NEST_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire msgd_pkg::head_t              head,
    output logic                              pop,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [msgd_pkg::OUT_W-1:0]        m_tdata,
    output logic                              m_tlast
);

    localparam int LW = $clog2(MAX_NEST + 1);
    localparam int IW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

    localparam logic [4:0] T_F32 = 5'h0a, T_F64 = 5'h0b, T_I8 = 5'h10, T_I16 = 5'h11;
    localparam logic [4:0] T_I32 = 5'h12, T_I64 = 5'h13;

    typedef enum logic [1:0] {M_TYPE, M_FIELD, M_PAYLOAD} mode_t;
    typedef enum logic [1:0] {S_RUN, S_RD, S_POP} state_t;

    state_t      state_reg, state_next;
    mode_t       mode_reg, mode_next;
    logic [4:0]  ptype_reg, ptype_next;
    logic [3:0]  fleft_reg, fleft_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] pleft_reg, pleft_next;
    logic [LW-1:0] level_reg, level_next;
    logic [32:0] top_reg, top_next;
    logic [31:0] len_reg, len_next;
    logic        disc_reg, disc_next;

    msgd_pkg::kind_t h_kind_reg, h_kind_next;
    logic [63:0] h_value_reg, h_value_next;
    logic [31:0] h_count_reg, h_count_next;
    logic [LW-1:0] h_level_reg, h_level_next;
    logic        h_end_reg, h_end_next, h_emit_reg, h_emit_next;

    logic        out_v_reg, out_v_next;
    logic [msgd_pkg::OUT_W-1:0] out_d_reg, out_d_next;
    logic        out_l_reg, out_l_next;

    logic [32:0] mem [MAX_NEST];
    logic [32:0] rd_reg;
    logic        we;
    logic [IW-1:0] addr;

    msgd_pkg::qent_t e;
    logic        run, fin, done;
    msgd_pkg::kind_t c_kind;
    logic [63:0] c_value, a;
    logic [31:0] c_count, len_inc, pl, oc_n;
    logic        c_emit, c_complete, oc, oc_map, os;
    msgd_pkg::err_t c_err;
    logic [3:0]  fl;
    logic [32:0] t;

    assign e    = head.ent;
    assign run  = (state_reg == S_RUN) && head.valid && (!out_v_reg || m_tready);
    assign pop  = run;
    assign addr = IW'(level_reg - LW'(1));

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;
    assign m_tlast  = out_l_reg;

    function automatic logic [msgd_pkg::OUT_W-1:0] pack(
        input logic [3:0] k, input logic [63:0] v, input logic [31:0] c,
        input logic [LW-1:0] lv, input logic [31:0] n,
        input msgd_pkg::err_t er);
        return {5'b0, er, n, 5'(lv), c, v, k};
    endfunction

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        ptype_next = ptype_reg;
        fleft_next = fleft_reg;
        acc_next   = acc_reg;
        pleft_next = pleft_reg;
        level_next = level_reg;
        top_next   = top_reg;
        len_next   = len_reg;
        disc_next  = disc_reg;
        h_kind_next  = h_kind_reg;
        h_value_next = h_value_reg;
        h_count_next = h_count_reg;
        h_level_next = h_level_reg;
        h_end_next   = h_end_reg;
        h_emit_next  = h_emit_reg;
        out_v_next = out_v_reg && !m_tready;
        out_d_next = out_d_reg;
        out_l_next = out_l_reg;
        we         = 1'b0;
        c_kind = msgd_pkg::K_NIL;
        c_value = '0;
        c_count = '0;
        c_emit = 1'b0;
        c_complete = 1'b0;
        c_err = msgd_pkg::E_NONE;
        oc = 1'b0;
        oc_map = 1'b0;
        os = 1'b0;
        oc_n = '0;
        a = '0;
        fl = '0;
        pl = '0;
        t = '0;
        fin = 1'b0;
        done = 1'b0;
        len_inc = (len_reg == 32'hffffffff) ? len_reg : len_reg + 32'd1;

        if (run && disc_reg) begin
            if (e.last) begin
                mode_next = M_TYPE; ptype_next = '0; fleft_next = '0; acc_next = '0;
                pleft_next = '0; level_next = '0; len_next = '0; disc_next = 1'b0;
            end
        end else if (run) begin
            len_next = len_inc;
            unique case (mode_reg)
                M_FIELD: begin
                    a = {acc_reg[55:0], e.data};
                    acc_next = a;
                    fl = (fleft_reg == 4'd0) ? 4'd0 : fleft_reg - 4'd1;
                    fleft_next = fl;
                    if (fl == 4'd0) begin
                        mode_next = M_TYPE;
                        c_emit = 1'b1;
                        c_complete = 1'b1;
                        case (ptype_reg) inside
                            T_F32: begin
                                c_kind = msgd_pkg::K_F32; c_value = {32'b0, a[31:0]};
                            end
                            T_F64: begin
                                c_kind = msgd_pkg::K_F64; c_value = a;
                            end
                            [5'h0c:5'h0f]: begin
                                c_kind = msgd_pkg::K_UINT; c_value = a;
                            end
                            T_I8: begin
                                c_kind = msgd_pkg::K_INT; c_value = {{56{a[7]}}, a[7:0]};
                            end
                            T_I16: begin
                                c_kind = msgd_pkg::K_INT; c_value = {{48{a[15]}}, a[15:0]};
                            end
                            T_I32: begin
                                c_kind = msgd_pkg::K_INT; c_value = {{32{a[31]}}, a[31:0]};
                            end
                            T_I64: begin
                                c_kind = msgd_pkg::K_INT; c_value = a;
                            end
                            5'h1a, 5'h1b: begin
                                os = 1'b1; oc_n = a[31:0]; c_complete = 1'b0;
                            end
                            5'h1c, 5'h1d: begin
                                oc = 1'b1; oc_n = a[31:0]; c_complete = 1'b0;
                            end
                            5'h1e, 5'h1f: begin
                                oc = 1'b1; oc_map = 1'b1; oc_n = a[31:0]; c_complete = 1'b0;
                            end
                            default: begin
                                c_emit = 1'b0; c_complete = 1'b0; c_err = msgd_pkg::E_BAD;
                            end
                        endcase
                    end
                end
                M_PAYLOAD: begin
                    c_kind  = msgd_pkg::K_STRBYTE;
                    c_value = {56'b0, e.data};
                    c_emit  = 1'b1;
                    pl = (pleft_reg == 32'd0) ? 32'd0 : pleft_reg - 32'd1;
                    pleft_next = pl;
                    if (pl == 32'd0) begin
                        c_complete = 1'b1;
                        mode_next = M_TYPE;
                    end
                end
                default: begin
                    unique case (e.cls.op)
                        msgd_pkg::OP_SCALAR: begin
                            c_kind = e.cls.kind;
                            c_emit = 1'b1;
                            c_complete = 1'b1;
                            if (e.cls.kind == msgd_pkg::K_UINT)
                                c_value = {56'b0, e.cls.value};
                            else if (e.cls.kind == msgd_pkg::K_INT)
                                c_value = {{56{e.cls.value[7]}}, e.cls.value};
                        end
                        msgd_pkg::OP_ARRAY: begin
                            oc = 1'b1; oc_n = {27'b0, e.cls.count};
                        end
                        msgd_pkg::OP_MAP: begin
                            oc = 1'b1; oc_map = 1'b1; oc_n = {27'b0, e.cls.count};
                        end
                        msgd_pkg::OP_STR: begin
                            os = 1'b1; oc_n = {27'b0, e.cls.count};
                        end
                        msgd_pkg::OP_FIELD: begin
                            ptype_next = e.data[4:0];
                            fleft_next = e.cls.nbytes;
                            acc_next   = '0;
                            mode_next  = M_FIELD;
                        end
                        default: c_err = msgd_pkg::E_BAD;
                    endcase
                end
            endcase

            if (oc) begin
                c_emit  = 1'b1;
                c_kind  = oc_map ? msgd_pkg::K_MAP : msgd_pkg::K_ARRAY;
                c_count = oc_n;
                if (oc_n == 32'd0) begin
                    c_complete = 1'b1;
                end else if (level_reg >= LW'(MAX_NEST)) begin
                    c_err = msgd_pkg::E_DEEP;
                end else begin
                    we = (level_reg != '0);
                    top_next = oc_map ? {oc_n, 1'b0} : {1'b0, oc_n};
                    level_next = level_reg + LW'(1);
                end
            end
            if (os) begin
                c_emit  = 1'b1;
                c_kind  = msgd_pkg::K_STRHDR;
                c_count = oc_n;
                if (oc_n == 32'd0) begin
                    c_complete = 1'b1;
                end else begin
                    pleft_next = oc_n;
                    mode_next  = M_PAYLOAD;
                end
            end

            h_kind_next  = c_kind;
            h_value_next = c_value;
            h_count_next = c_count;
            h_level_next = level_reg;
            h_end_next   = e.last;
            h_emit_next  = c_emit;

            if (c_err != msgd_pkg::E_NONE) begin
                out_v_next = 1'b1;
                out_l_next = 1'b0;
                out_d_next = pack(4'd0, 64'd0, 32'd0, level_reg, len_inc, c_err);
                if (e.last) begin
                    mode_next = M_TYPE; ptype_next = '0; fleft_next = '0; acc_next = '0;
                    pleft_next = '0; level_next = '0; len_next = '0; disc_next = 1'b0;
                end else begin
                    disc_next = 1'b1;
                    mode_next = M_TYPE;
                end
            end else if (c_complete && level_reg != '0) begin
                t = top_reg - 33'd1;
                if (t != 33'd0) begin
                    top_next = t;
                    fin = 1'b1;
                end else begin
                    level_next = level_reg - LW'(1);
                    if (level_next == '0) begin
                        fin = 1'b1; done = 1'b1;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end else begin
                fin = 1'b1;
                done = c_complete;
            end
        end else if (state_reg == S_RD) begin
            state_next = S_POP;
        end else if (state_reg == S_POP) begin
            t = rd_reg - 33'd1;
            if (t != 33'd0) begin
                top_next = t;
                fin = 1'b1;
                state_next = S_RUN;
            end else begin
                level_next = level_reg - LW'(1);
                if (level_next == '0) begin
                    fin = 1'b1; done = 1'b1; state_next = S_RUN;
                end else begin
                    state_next = S_RD;
                end
            end
        end

        if (fin) begin
            if (h_end_next && !done) begin
                out_v_next = 1'b1;
                out_l_next = 1'b0;
                out_d_next = pack(4'd0, 64'd0, 32'd0, h_level_next, len_next,
                                  msgd_pkg::E_SHORT);
                mode_next = M_TYPE; ptype_next = '0; fleft_next = '0; acc_next = '0;
                pleft_next = '0; level_next = '0; len_next = '0; disc_next = 1'b0;
            end else if (h_emit_next) begin
                out_v_next = 1'b1;
                out_l_next = done;
                out_d_next = pack(h_kind_next, h_value_next, h_count_next, h_level_next,
                                  len_next, msgd_pkg::E_NONE);
                if (done) len_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (we) mem[addr] <= top_reg;
        rd_reg <= mem[addr];
    end

    always_ff @(posedge aclk) begin
        ptype_reg   <= ptype_next;
        fleft_reg   <= fleft_next;
        acc_reg     <= acc_next;
        pleft_reg   <= pleft_next;
        top_reg     <= top_next;
        h_kind_reg  <= h_kind_next;
        h_value_reg <= h_value_next;
        h_count_reg <= h_count_next;
        h_level_reg <= h_level_next;
        h_end_reg   <= h_end_next;
        h_emit_reg  <= h_emit_next;
        out_d_reg   <= out_d_next;
        out_l_reg   <= out_l_next;
        if (!aresetn) begin
            state_reg <= S_RUN;
            mode_reg  <= M_TYPE;
            level_reg <= '0;
            len_reg   <= '0;
            disc_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            level_reg <= level_next;
            len_reg   <= len_next;
            disc_reg  <= disc_next;
            out_v_reg <= out_v_next;
        end
    end

endmodule

`default_nettype wire

/* design/msgpack_stream_decoder_top.sv */
// ----------------------------------------------------------------------------
// msgpack_stream_decoder_top
// Streaming MessagePack decoder: one encoded byte per input word, one token
// per completed value, header or string byte. The back end takes a byte in
// its run state while its output register is empty or being taken. A byte
// that completes the last element of containers goes through S_RD and S_POP
// for each closed level that leaves a parent open, for the registered read of
// the parent count from the count stack memory; closing the outermost skips both.
// Output word fields, low bit up: token_kind[3:0], token_value[67:4],
// item_count[99:68], nest_level[104:100], bytes_consumed[136:105],
// error_code[138:137]; m_tlast is object_done.
// ----------------------------------------------------------------------------
`default_nettype none

module msgpack_stream_decoder_top #(
    parameter int MAX_NEST = msgd_pkg::MAX_NEST_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [7:0]               s_tdata,   // stream_byte
    input  wire logic                     s_tlast,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [msgd_pkg::OUT_W-1:0]    m_tdata,   // kind, value, count, nest, bytes, err
    output logic                          m_tlast
);

    msgd_pkg::head_t head;
    logic            pop;

    msgd_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tlast(s_tlast), .head(head), .pop(pop)
    );

    msgd_back #(.MAX_NEST(MAX_NEST)) u_back (
        .aclk(aclk), .aresetn(aresetn), .head(head), .pop(pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

endmodule

`default_nettype wire

/* design/msgd_checker.sv */
// ----------------------------------------------------------------------------
// msgd_checker
// Port-level checks on the decoder token stream.
// ----------------------------------------------------------------------------
`default_nettype none

module msgd_checker (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [msgd_pkg::OUT_W-1:0] m_tdata,
    input wire logic                  m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[138:137] != 2'd0 |->
            m_tdata[3:0] == 4'd0 && m_tdata[99:68] == 32'd0 && !m_tlast)
        else $error("error word carries token fields");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[3:0] <= 4'd10)
        else $error("token kind out of range");

    a_strbyte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:0] == 4'd8 |-> m_tdata[99:68] == 32'd0
            && m_tdata[67:12] == 56'd0)
        else $error("string byte word malformed");

endmodule

bind msgpack_stream_decoder_top msgd_checker u_msgd_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast)
);

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the MessagePack stream decoder against a byte-level decoder model
// kept in the bench. Directed buffers cover a selection of type byte forms and the
// error cases. Random buffers then mix well-formed objects with truncated,
// corrupt and over-nested ones, under random input gaps and output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int NEST = msgd_pkg::MAX_NEST_DEF;

    typedef enum logic [1:0] {PM_TYPE, PM_FIELD, PM_PAYLOAD} pmode_t;

    typedef struct packed {
        msgd_pkg::kind_t kind;
        logic [63:0]     value;
        logic [31:0]     count;
        logic [4:0]      nest;
        logic            done;
        logic [31:0]     nbytes;
        msgd_pkg::err_t  err;
    } token_t;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_tvalid = 0;
    logic               s_tready;
    logic [7:0]         s_tdata = 0;
    logic               s_tlast = 0;
    logic               m_tvalid;
    logic               m_tready = 0;
    logic [msgd_pkg::OUT_W-1:0] m_tdata;
    logic               m_tlast;

    msgpack_stream_decoder_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    // decoder state
    pmode_t      mode;
    logic [7:0]  ftype;
    logic [3:0]  fleft;
    logic [63:0] acc;
    logic [31:0] pleft;
    logic [32:0] owed [NEST];
    logic [4:0]  lvl;
    logic [31:0] olen;
    logic        skip;

    // token being built
    msgd_pkg::kind_t tk_kind;
    logic [63:0] tk_value;
    logic [31:0] tk_count;
    logic        tk_emit, tk_complete;
    msgd_pkg::err_t tk_err;

    token_t      tokens_due [$];
    logic [8:0]  bytes_out [$];
    logic [7:0]  obj [$];
    int          errors = 0;
    int          objects_seen = 0;
    int          errors_seen = 0;
    int          tokens_seen = 0;
    int          nbytes_queued = 0;

    function automatic void clear_state();
        mode = PM_TYPE; ftype = 0; fleft = 0; acc = 0; pleft = 0;
        lvl = 0; olen = 0; skip = 0;
    endfunction

    function automatic void take_scalar(msgd_pkg::kind_t k, logic [63:0] v);
        tk_kind = k; tk_value = v; tk_emit = 1; tk_complete = 1;
    endfunction

    function automatic void open_container(msgd_pkg::kind_t k, logic [31:0] n);
        tk_kind = k; tk_count = n; tk_emit = 1;
        if (n == 0) begin
            tk_complete = 1;
        end else if (lvl >= NEST) begin
            tk_err = msgd_pkg::E_DEEP;
        end else begin
            owed[lvl[3:0]] = (k == msgd_pkg::K_MAP) ? {n, 1'b0} : {1'b0, n};
            lvl++;
        end
    endfunction

    function automatic void open_string(logic [31:0] n);
        tk_kind = msgd_pkg::K_STRHDR; tk_count = n; tk_emit = 1;
        if (n == 0) begin
            tk_complete = 1;
        end else begin
            pleft = n;
            mode = PM_PAYLOAD;
        end
    endfunction

    function automatic void start_field(logic [7:0] t, logic [3:0] n);
        ftype = t; fleft = n; acc = 0; mode = PM_FIELD;
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic last);
        token_t     t;
        logic [4:0] lvl0;
        logic       done;
        lvl0 = lvl;
        done = 0;
        if (skip) begin
            if (last) clear_state();
            return;
        end
        if (olen != 32'hFFFF_FFFF) olen++;
        tk_kind = msgd_pkg::K_NIL; tk_value = 0; tk_count = 0;
        tk_emit = 0; tk_complete = 0; tk_err = msgd_pkg::E_NONE;
        if (mode == PM_FIELD) begin
            acc = {acc[55:0], b};
            if (fleft > 0) fleft--;
            if (fleft == 0) begin
                mode = PM_TYPE;
                case (ftype)
                    8'hca: take_scalar(msgd_pkg::K_F32, {32'b0, acc[31:0]});
                    8'hcb: take_scalar(msgd_pkg::K_F64, acc);
                    8'hcc, 8'hcd, 8'hce, 8'hcf: take_scalar(msgd_pkg::K_UINT, acc);
                    8'hd0: take_scalar(msgd_pkg::K_INT, {{56{acc[7]}}, acc[7:0]});
                    8'hd1: take_scalar(msgd_pkg::K_INT, {{48{acc[15]}}, acc[15:0]});
                    8'hd2: take_scalar(msgd_pkg::K_INT, {{32{acc[31]}}, acc[31:0]});
                    8'hd3: take_scalar(msgd_pkg::K_INT, acc);
                    8'hda, 8'hdb: open_string(acc[31:0]);
                    8'hdc, 8'hdd: open_container(msgd_pkg::K_ARRAY, acc[31:0]);
                    8'hde, 8'hdf: open_container(msgd_pkg::K_MAP, acc[31:0]);
                    default: tk_err = msgd_pkg::E_BAD;
                endcase
            end
        end else if (mode == PM_PAYLOAD) begin
            take_scalar(msgd_pkg::K_STRBYTE, {56'b0, b});
            if (pleft > 0) pleft--;
            if (pleft != 0) tk_complete = 0;
            else mode = PM_TYPE;
        end else begin
            if (b < 8'h80) take_scalar(msgd_pkg::K_UINT, {56'b0, b});
            else if (b <= 8'h8f) open_container(msgd_pkg::K_MAP, {28'b0, b[3:0]});
            else if (b <= 8'h9f) open_container(msgd_pkg::K_ARRAY, {28'b0, b[3:0]});
            else if (b <= 8'hbf) open_string({27'b0, b[4:0]});
            else if (b >= 8'he0) take_scalar(msgd_pkg::K_INT, {56'hFF_FFFF_FFFF_FFFF, b});
            else begin
                case (b)
                    8'hc0: take_scalar(msgd_pkg::K_NIL, 64'd0);
                    8'hc2: take_scalar(msgd_pkg::K_FALSE, 64'd0);
                    8'hc3: take_scalar(msgd_pkg::K_TRUE, 64'd0);
                    8'hcc, 8'hd0: start_field(b, 4'd1);
                    8'hcd, 8'hd1, 8'hda, 8'hdc, 8'hde: start_field(b, 4'd2);
                    8'hca, 8'hce, 8'hd2, 8'hdb, 8'hdd, 8'hdf: start_field(b, 4'd4);
                    8'hcb, 8'hcf, 8'hd3: start_field(b, 4'd8);
                    default: tk_err = msgd_pkg::E_BAD;
                endcase
            end
        end
        if (tk_err == msgd_pkg::E_NONE && tk_complete) begin
            while (lvl > 0) begin
                if (owed[4'(lvl - 5'd1)] > 0) owed[4'(lvl - 5'd1)]--;
                if (owed[4'(lvl - 5'd1)] != 0) break;
                lvl--;
            end
            if (lvl == 0) done = 1;
        end
        if (tk_err == msgd_pkg::E_NONE && last && !done) tk_err = msgd_pkg::E_SHORT;
        if (tk_err != msgd_pkg::E_NONE) begin
            t = '{msgd_pkg::K_NIL, 64'b0, 32'b0, lvl0, 1'b0, olen, tk_err};
            tokens_due.push_back(t);
            if (last) clear_state();
            else begin
                skip = 1;
                mode = PM_TYPE;
            end
            return;
        end
        if (!tk_emit) return;
        t = '{tk_kind, tk_value, tk_count, lvl0, done, olen, msgd_pkg::E_NONE};
        tokens_due.push_back(t);
        if (done) olen = 0;
    endfunction

    // stimulus building
    function automatic void send_buffer(logic [7:0] q [$]);
        foreach (q[i]) bytes_out.push_back({i == q.size() - 1, q[i]});
        nbytes_queued += q.size();
    endfunction

    function automatic void put_be(logic [63:0] v, int n);
        for (int i = n - 1; i >= 0; i--) obj.push_back(v[8*i +: 8]);
    endfunction

    function automatic void gen_value(int depth);
        int          sel;
        int          n;
        logic [7:0]  t;
        sel = $urandom_range(0, depth >= 3 ? 8 : 12);
        case (sel)
            0: obj.push_back(8'($urandom_range(0, 127)));
            1: begin
                n = $urandom_range(0, 2);
                obj.push_back(n == 0 ? 8'hc0 : n == 1 ? 8'hc2 : 8'hc3);
            end
            2: obj.push_back(8'($urandom_range(8'he0, 8'hff)));
            3, 4: begin
                t = (sel == 3) ? 8'($urandom_range(8'hcc, 8'hcf))
                               : 8'($urandom_range(8'hd0, 8'hd3));
                obj.push_back(t);
                put_be({$urandom, $urandom}, 1 << t[1:0]);
            end
            5: begin
                t = 8'($urandom_range(8'hca, 8'hcb));
                obj.push_back(t);
                put_be({$urandom, $urandom}, t[0] ? 8 : 4);
            end
            6: begin
                n = $urandom_range(0, 5);
                obj.push_back(8'ha0 | n[7:0]);
                repeat (n) obj.push_back(8'($urandom));
            end
            7, 8: begin
                n = $urandom_range(0, 4);
                t = 8'($urandom_range(8'hda, 8'hdb));
                obj.push_back(t);
                put_be(64'(n), t[0] ? 4 : 2);
                repeat (n) obj.push_back(8'($urandom));
            end
            9, 10: begin
                n = $urandom_range(0, 3);
                if ($urandom_range(0, 1)) obj.push_back(8'h90 | n[7:0]);
                else begin
                    t = 8'($urandom_range(8'hdc, 8'hdd));
                    obj.push_back(t);
                    put_be(64'(n), t[0] ? 4 : 2);
                end
                repeat (n) gen_value(depth + 1);
            end
            default: begin
                n = $urandom_range(0, 2);
                if ($urandom_range(0, 1)) obj.push_back(8'h80 | n[7:0]);
                else begin
                    t = 8'($urandom_range(8'hde, 8'hdf));
                    obj.push_back(t);
                    put_be(64'(n), t[0] ? 4 : 2);
                end
                repeat (2 * n) gen_value(depth + 1);
            end
        endcase
    endfunction

    function automatic logic [7:0] bad_type();
        int r;
        r = $urandom_range(0, 12);
        return r == 0 ? 8'hc1 : r <= 6 ? 8'hc3 + r[7:0] : 8'hcd + r[7:0];
    endfunction

    function automatic void nest_run(int depth);
        obj = {};
        repeat (depth) obj.push_back(8'h91);
        obj.push_back(8'hc0);
        send_buffer(obj);
    endfunction

    // sender
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
        end else begin
            if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 0;
                end else if (bytes_out.size() > 0) begin
                    {s_tlast, s_tdata} <= bytes_out.pop_front();
                    s_tvalid <= 1;
                    if (burst_left > 0) burst_left--;
                    else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // receiver
    int cyc = 0;
    int stall_mode = 0;

    always @(posedge aclk) begin
        cyc++;
        if (cyc % 128 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (cyc % 4 == 0);
            default: m_tready <= (cyc % 23) > 9;
        endcase
    end

    // checker
    always @(posedge aclk) begin
        token_t want;
        token_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{msgd_pkg::kind_t'(m_tdata[3:0]), m_tdata[67:4], m_tdata[99:68],
                    m_tdata[104:100], m_tlast, m_tdata[136:105],
                    msgd_pkg::err_t'(m_tdata[138:137])};
            tokens_seen++;
            if (got.done) objects_seen++;
            if (got.err != msgd_pkg::E_NONE) errors_seen++;
            if (tokens_due.size() == 0) begin
                $display("%0t: unexpected token kind %0d err %0d", $time, got.kind, got.err);
                errors++;
            end else begin
                want = tokens_due.pop_front();
                if (got != want) begin
                    $display("%0t: mismatch expected kind %0d val %h cnt %0d nest %0d done %0d len %0d err %0d",
                             $time, want.kind, want.value, want.count, want.nest, want.done,
                             want.nbytes, want.err);
                    $display("%0t:          actual   kind %0d val %h cnt %0d nest %0d done %0d len %0d err %0d",
                             $time, got.kind, got.value, got.count, got.nest, got.done,
                             got.nbytes, got.err);
                    errors++;
                end
            end
        end
    end

    initial begin
        int r;
        int cut;
        clear_state();
        send_buffer('{8'hc0});
        send_buffer('{8'hc2});
        send_buffer('{8'hc3});
        send_buffer('{8'h00});
        send_buffer('{8'h7f});
        send_buffer('{8'he0});
        send_buffer('{8'hff});
        send_buffer('{8'hcf, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
        send_buffer('{8'hd0, 8'h80});
        send_buffer('{8'hd1, 8'h80, 8'h00});
        send_buffer('{8'hd2, 8'h80, 8'h00, 8'h00, 8'h00});
        send_buffer('{8'hd3, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01});
        send_buffer('{8'hca, 8'hff, 8'hff, 8'hff, 8'hff});
        send_buffer('{8'ha0});
        send_buffer('{8'hbf, 8'h41});
        send_buffer('{8'hdb, 8'h00, 8'h00, 8'h00, 8'h01, 8'h5a, 8'h90, 8'h80});
        send_buffer('{8'hde, 8'h00, 8'h01, 8'hc0, 8'h92, 8'hc3, 8'ha1, 8'h7e});
        send_buffer('{8'hc1, 8'h00, 8'h11});
        send_buffer('{8'hc4});
        send_buffer('{8'hd9, 8'h01, 8'h61});
        send_buffer('{8'h93, 8'h01, 8'h02});
        send_buffer('{8'hdf, 8'h00, 8'h00, 8'h00, 8'h01, 8'hc0});
        nest_run(NEST);
        nest_run(NEST + 1);
        while (nbytes_queued < 700) begin
            r = $urandom_range(0, 11);
            obj = {};
            gen_value(0);
            if (r < 7) begin
                if (r == 0) gen_value(0);
                send_buffer(obj);
            end else if (r < 9) begin
                if (obj.size() > 1) begin
                    cut = $urandom_range(1, obj.size() - 1);
                    while (obj.size() > cut) void'(obj.pop_back());
                end
                send_buffer(obj);
            end else if (r == 9) begin
                cut = $urandom_range(0, obj.size() - 1);
                obj.insert(cut, bad_type());
                send_buffer(obj);
            end else if (r == 10) begin
                obj = {};
                repeat ($urandom_range(1, 6)) obj.push_back(8'($urandom));
                send_buffer(obj);
            end else begin
                nest_run($urandom_range(NEST - 1, NEST + 2));
            end
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        wait (bytes_out.size() == 0 && !s_tvalid && tokens_due.size() == 0);
        repeat (100) @(posedge aclk);
        $display("tb: %0d bytes in, %0d tokens checked, %0d objects closed, %0d error tokens",
                 nbytes_queued, tokens_seen, objects_seen, errors_seen);
        if (errors == 0 && tokens_due.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("tb: timeout");
        $display("tb: errors");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
design/msgd_pkg.sv
design/msgd_front.sv
design/msgd_back.sv
design/msgpack_stream_decoder_top.sv
design/msgd_checker.sv
bench/tb.sv
